/* hdl/dfc_pkg.sv */
`default_nettype none
package dfc_pkg;

	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 64;

	localparam logic [7:0] START_BYTE = 8'h68;
	localparam logic [7:0] END_BYTE = 8'h16;
	localparam int unsigned FRAME_OVERHEAD = 26;
	localparam int unsigned HEAD_LAST_POS = 22;
	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	typedef enum logic [1:0] {
		REG_STATION = 2'd0,
		REG_DIRECTION = 2'd1,
		REG_FLAG = 2'd2,
		REG_ORDER = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_HEAD,
		PH_DATA,
		PH_CRC,
		PH_END
	} phase_t;

	typedef enum logic [3:0] {
		ST_OK = 4'd0,
		ST_TRUNCATED = 4'd1,
		ST_LENGTH = 4'd2,
		ST_END_BYTE = 4'd3,
		ST_CRC = 4'd4,
		ST_DIRECTION = 4'd5,
		ST_FLAG = 4'd6,
		ST_ADDRESS = 4'd7,
		ST_FUNCTION = 4'd8
	} status_t;

	typedef struct packed {
		logic [55:0] station_address;
		logic [7:0] expected_direction;
		logic [7:0] expected_flag;
		logic word_byte_order;
	} cfg_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic buffer_end;
	} in_item_t;

	typedef struct packed {
		logic kind;
		logic [7:0] data_byte;
		logic [9:0] data_index;
		logic [3:0] status;
		logic [15:0] function_code;
		logic [7:0] direction_byte;
		logic [7:0] flag_byte;
		logic [55:0] frame_address;
		logic [55:0] packet_ident;
		logic [10:0] data_length;
		logic last;
	} out_item_t;

	// reflected fcs16, one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// place one byte of a two-byte field, order set means first byte high
	function automatic logic [15:0] put_word_byte(input logic [15:0] old, input logic [7:0] b,
			input logic first, input logic order);
		if (order == first) begin
			return {b, old[7:0]};
		end
		return {old[15:8], b};
	endfunction

	function automatic logic code_known(input logic [15:0] code);
		logic known;
		known = 1'b0;
		case (code) inside
			16'h2001, 16'h2002, 16'h2003, 16'h2004,
			16'h2011, 16'h2012, 16'h2013, 16'h2014, 16'h2015, 16'h2016,
			16'h2021, 16'h2022, 16'h2023, 16'h2024,
			16'h2031, 16'h2032, 16'h2033, 16'h2034, 16'h2035, 16'h2036,
			16'h2041, 16'h2042, 16'h2043, 16'h2044,
			16'h2051, 16'h2052, 16'h2053,
			16'h2061, 16'h2062: known = 1'b1;
			default: known = 1'b0;
		endcase
		return known;
	endfunction

endpackage
`default_nettype wire

/* hdl/dfc_regs.sv */
`default_nettype none
module dfc_regs
	import dfc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [APB_ADDR_W-1:0] paddr,
	input wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	cfg_t cfg_q;
	reg_idx_t idx;
	logic wr_en;

	assign idx = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_STATION: cfg_q.station_address <= pwdata[55:0];
				REG_DIRECTION: cfg_q.expected_direction <= pwdata[7:0];
				REG_FLAG: cfg_q.expected_flag <= pwdata[7:0];
				REG_ORDER: cfg_q.word_byte_order <= pwdata[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_STATION: prdata[55:0] = cfg_q.station_address;
			REG_DIRECTION: prdata[7:0] = cfg_q.expected_direction;
			REG_FLAG: prdata[7:0] = cfg_q.expected_flag;
			REG_ORDER: prdata[0] = cfg_q.word_byte_order;
			default: prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/dfc_frame.sv */
`default_nettype none
module dfc_frame
	import dfc_pkg::*;
#(
	parameter int unsigned MAX_DATA_BYTES = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic byte_valid,
	output logic byte_ready,
	input wire in_item_t byte_item,
	input wire logic room,
	output logic push,
	output out_item_t push_item
);

	localparam int unsigned CW = $clog2(MAX_DATA_BYTES + 1);
	localparam logic [16:0] MaxData = 17'(MAX_DATA_BYTES);
	localparam logic [16:0] MaxPacket = 17'(MAX_DATA_BYTES + FRAME_OVERHEAD);
	localparam logic [CW-1:0] HeadLast = CW'(HEAD_LAST_POS);

	logic valid_s1;
	in_item_t item_s1;
	logic fire;

	phase_t phase_q, phase_d;
	logic [CW-1:0] cnt_q, cnt_d, cnt_nx;
	logic [15:0] crc_q, crc_d;
	logic [15:0] pkt_len_q, pkt_len_d;
	logic [15:0] pay_len_q, pay_len_d;
	logic [15:0] func_q, func_d;
	logic [7:0] dir_q, dir_d;
	logic [7:0] flag_q, flag_d;
	logic [55:0] addr_q, addr_d;
	logic [55:0] ident_q, ident_d;
	logic [15:0] rcrc_q, rcrc_d;

	logic emit;
	status_t st;
	logic data_out;
	logic [16:0] sat_len;
	logic [7:0] b;

	assign fire = valid_s1 && room;
	assign byte_ready = !valid_s1 || room;
	assign b = item_s1.rx_byte;
	assign cnt_nx = cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
	end

	always_comb begin
		phase_d = phase_q;
		cnt_d = cnt_q;
		crc_d = crc_q;
		pkt_len_d = pkt_len_q;
		pay_len_d = pay_len_q;
		func_d = func_q;
		dir_d = dir_q;
		flag_d = flag_q;
		addr_d = addr_q;
		ident_d = ident_q;
		rcrc_d = rcrc_q;
		emit = 1'b0;
		st = ST_OK;
		data_out = 1'b0;
		if (fire) begin
			if (item_s1.buffer_end) begin
				if (phase_q != PH_HUNT) begin
					emit = 1'b1;
					st = ST_TRUNCATED;
				end
			end else begin
				case (phase_q)
					PH_HEAD: begin
						cnt_d = cnt_nx;
						crc_d = crc_byte(crc_q, b);
						case (cnt_nx)
							CW'(1), CW'(2): pkt_len_d = put_word_byte(pkt_len_q, b,
								cnt_nx == CW'(1), cfg.word_byte_order);
							CW'(3): func_d[15:8] = b;
							CW'(4): func_d[7:0] = b;
							CW'(5): dir_d = b;
							CW'(6): flag_d = b;
							CW'(21), CW'(22): pay_len_d = put_word_byte(pay_len_q, b,
								cnt_nx == CW'(21), cfg.word_byte_order);
							default: begin
								if (cnt_nx >= CW'(7) && cnt_nx <= CW'(13)) begin
									addr_d[8*(int'(cnt_nx) - 7) +: 8] = b;
								end else if (cnt_nx >= CW'(14) && cnt_nx <= CW'(20)) begin
									ident_d[8*(int'(cnt_nx) - 14) +: 8] = b;
								end
							end
						endcase
						if (cnt_nx >= HeadLast) begin
							if ({1'b0, pay_len_d} > MaxData || {1'b0, pkt_len_d} > MaxPacket) begin
								emit = 1'b1;
								st = ST_LENGTH;
							end else begin
								cnt_d = '0;
								phase_d = (pay_len_d == 16'd0) ? PH_CRC : PH_DATA;
							end
						end
					end
					PH_DATA: begin
						crc_d = crc_byte(crc_q, b);
						data_out = 1'b1;
						cnt_d = cnt_nx;
						if (16'(cnt_nx) >= pay_len_q) begin
							cnt_d = '0;
							phase_d = PH_CRC;
						end
					end
					PH_CRC: begin
						rcrc_d = put_word_byte(rcrc_q, b, cnt_q == '0, cfg.word_byte_order);
						cnt_d = cnt_nx;
						if (cnt_nx >= CW'(2)) begin
							cnt_d = '0;
							phase_d = PH_END;
						end
					end
					PH_END: begin
						emit = 1'b1;
						if (b != END_BYTE) begin
							st = ST_END_BYTE;
						end else if (crc_q != rcrc_q) begin
							st = ST_CRC;
						end else if (dir_q != cfg.expected_direction) begin
							st = ST_DIRECTION;
						end else if (flag_q != cfg.expected_flag) begin
							st = ST_FLAG;
						end else if (addr_q != cfg.station_address) begin
							st = ST_ADDRESS;
						end else if (!code_known(func_q)) begin
							st = ST_FUNCTION;
						end else begin
							st = ST_OK;
						end
					end
					default: begin
						phase_d = PH_HUNT;
						if (b == START_BYTE) begin
							cnt_d = '0;
							crc_d = crc_byte(CRC_INIT, b);
							pkt_len_d = '0;
							pay_len_d = '0;
							func_d = '0;
							dir_d = '0;
							flag_d = '0;
							addr_d = '0;
							ident_d = '0;
							rcrc_d = '0;
							phase_d = PH_HEAD;
						end
					end
				endcase
			end
			if (emit) begin
				phase_d = PH_HUNT;
				cnt_d = '0;
			end
		end
	end

	// status reports the length as updated by this byte
	assign sat_len = ({1'b0, pay_len_d} > MaxData) ? MaxData : {1'b0, pay_len_d};

	always_comb begin
		push_item = '0;
		push = emit || data_out;
		if (data_out) begin
			push_item.data_byte = b;
			push_item.data_index = 10'(cnt_q);
		end else begin
			push_item.kind = 1'b1;
			push_item.status = st;
			push_item.function_code = func_d;
			push_item.direction_byte = dir_d;
			push_item.flag_byte = flag_d;
			push_item.frame_address = addr_d;
			push_item.packet_ident = ident_d;
			push_item.data_length = sat_len[10:0];
			push_item.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q <= '0;
			crc_q <= CRC_INIT;
			pkt_len_q <= '0;
			pay_len_q <= '0;
			func_q <= '0;
			dir_q <= '0;
			flag_q <= '0;
			addr_q <= '0;
			ident_q <= '0;
			rcrc_q <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			crc_q <= crc_d;
			pkt_len_q <= pkt_len_d;
			pay_len_q <= pay_len_d;
			func_q <= func_d;
			dir_q <= dir_d;
			flag_q <= flag_d;
			addr_q <= addr_d;
			ident_q <= ident_d;
			rcrc_q <= rcrc_d;
		end
	end

endmodule
`default_nettype wire

/* hdl/dfc_out_buf.sv */
`default_nettype none
module dfc_out_buf
	import dfc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire out_item_t push_item,
	output logic room,
	output logic res_valid,
	input wire logic res_ready,
	output out_item_t res_item
);

	out_item_t slot_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic pop;

	// room comes from registers only, so the receiver never reaches byte_ready
	assign room = (count_q != 2'd2);
	assign res_valid = (count_q != 2'd0);
	assign res_item = slot_q[rd_ptr_q];
	assign pop = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

/* hdl/delimited_frame_checker_crc16.sv */
// Frame checker for 0x68 ... 0x16 delimited frames with an fcs16 check.
// Byte channel: byte_valid/byte_ready/byte_item carry one received byte per
// transaction, or an end-of-buffer mark (buffer_end) that closes a partial frame.
// Result channel: res_valid/res_ready/res_item carry either one payload byte
// (kind 0) or the frame status (kind 1, last 1) at the end of a frame.
// Configuration: APB port, 64-bit registers at byte addresses 0x00 station
// address, 0x08 expected direction, 0x10 expected flag, 0x18 byte order.
// Write only while no byte is in flight.
// Path: an accepted byte waits in the input register; its result, if any, is
// written into the result buffer and visible from there. Throughput: one byte
// per cycle while the buffer has room, set by the combinational parse/crc update.
// Reset: frame state returns to start-byte search, crc to 0xFFFF, other frame
// fields and configuration registers to zero, result buffer empty.
// Receiver stall: a two-entry result buffer absorbs the results; once it is
// full and a byte waits in the input register, byte_ready drops until the
// receiver takes a result.
`default_nettype none
module delimited_frame_checker_crc16
	import dfc_pkg::*;
#(
	parameter int unsigned MAX_DATA_BYTES = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [APB_ADDR_W-1:0] paddr,
	input wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready,
	input wire logic byte_valid,
	output logic byte_ready,
	input wire in_item_t byte_item,
	output logic res_valid,
	input wire logic res_ready,
	output out_item_t res_item
);

	cfg_t cfg;
	logic room;
	logic push;
	out_item_t push_item;

	dfc_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	dfc_frame #(
		.MAX_DATA_BYTES(MAX_DATA_BYTES)
	) u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item(byte_item),
		.room(room),
		.push(push),
		.push_item(push_item)
	);

	dfc_out_buf u_out_buf (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.room(room),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item(res_item)
	);

endmodule
`default_nettype wire

/* hdl/dfc_checker.sv */
`default_nettype none
module dfc_checker
	import dfc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic byte_ready,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire out_item_t res_item
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	// the input side only backs up after the receiver has held off a result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> $past(res_valid && !res_ready))
		else $error("byte_ready low without a receiver stall");

	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.kind |-> res_item.last && res_item.data_byte == 8'd0
			&& res_item.data_index == 10'd0 && res_item.status <= 4'd8)
		else $error("malformed status transaction");

	a_data_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.kind |-> !res_item.last && res_item.status == 4'd0
			&& res_item.function_code == 16'd0 && res_item.data_length == 11'd0)
		else $error("malformed data transaction");

endmodule

bind delimited_frame_checker_crc16 dfc_checker u_dfc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.byte_ready(byte_ready),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res_item(res_item)
);
`default_nettype wire
